// ===== design/pcr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the particle collision response pipeline.
// No dependencies; every other design file imports this package.
package pcr_pkg;

   localparam int FRAC_BITS = 16;

   localparam logic [16:0] ONE_Q      = 17'd1 << FRAC_BITS;
   localparam logic [18:0] FRICT_MAX  = 19'd4 << FRAC_BITS;
   localparam logic signed [65:0] HALF_Q = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [50:0] ONE_S  = 51'sd1 <<< FRAC_BITS;
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   // register indexes of the configuration port
   localparam logic [7:0] CSR_RADIUS      = 8'd0;
   localparam logic [7:0] CSR_RESTITUTION = 8'd1;
   localparam logic [7:0] CSR_FRICTION    = 8'd2;
   localparam logic [7:0] CSR_GEO_VALID   = 8'd3;

   typedef struct packed {
      logic [30:0] radius;
      logic [16:0] restitution;
      logic [18:0] friction;
      logic        geo_valid;
   } cfg_type;

   // one request as it travels down the pipeline; each stage fills in its own fields
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] near_x;
      logic signed [31:0] near_y;
      logic signed [31:0] wall_x;
      logic signed [31:0] wall_y;
      logic signed [17:0] nrm_x;
      logic signed [17:0] nrm_y;
      logic [30:0]        surf_dist;
      logic               in_surf;
      logic               hit;
      logic               neg;
      logic               lt_zero;
      logic signed [31:0] rel_x;
      logic signed [31:0] rel_y;
      logic signed [49:0] pp_x;
      logic signed [49:0] pp_y;
      logic signed [50:0] dot;
      logic signed [31:0] vn;
      logic signed [49:0] nnp_x;
      logic signed [49:0] nnp_y;
      logic signed [31:0] nn_x;
      logic signed [31:0] nn_y;
      logic signed [31:0] tan_x;
      logic signed [31:0] tan_y;
      logic signed [31:0] d_x;
      logic signed [31:0] d_y;
      logic signed [31:0] rn_x;
      logic signed [31:0] rn_y;
      logic signed [50:0] dp_x;
      logic signed [50:0] dp_y;
      logic signed [50:0] rp_x;
      logic signed [50:0] rp_y;
      logic [63:0]        sq_x;
      logic [63:0]        sq_y;
      logic [63:0]        sd_x;
      logic [63:0]        sd_y;
      logic [63:0]        lt2;
      logic [63:0]        ld2;
      logic [35:0]        lt_rem;
      logic [35:0]        ld_rem;
      logic [31:0]        lt_root;
      logic [31:0]        ld_root;
      logic [50:0]        div_rem;
      logic [16:0]        quot;
   } item_type;

   // round to FRAC_BITS, halves toward +infinity
   function automatic logic signed [65:0] rnd(input logic signed [65:0] v);
      return (v + HALF_Q) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== design/pcr_front.sv =====
// Front pipeline: relative velocity, contact test, projection and the squared lengths.
// Depends on pcr_pkg.
module pcr_front import pcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int NSTG = 9;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_prev;
   logic [NSTG:0]   rdy;
   item_type        st_ff [NSTG];
   item_type        st_in [NSTG];
   item_type        prev  [NSTG];

   assign vld_prev = {vld_ff[NSTG-2:0], in_valid};

   always_comb begin
      rdy[NSTG] = out_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
      prev[0] = in_item;
      for (int k = 1; k < NSTG; k++) begin
         prev[k] = st_ff[k-1];
      end
   end

   always_comb begin
      logic signed [50:0] e_s;
      e_s = signed'(51'(cfg.restitution));
      for (int k = 0; k < NSTG; k++) begin
         st_in[k] = prev[k];
         case (k)
         0: begin
            st_in[k].rel_x = sat32(66'(prev[k].vel_x) - 66'(prev[k].wall_x));
            st_in[k].rel_y = sat32(66'(prev[k].vel_y) - 66'(prev[k].wall_y));
            st_in[k].hit   = cfg.geo_valid
                             & (prev[k].in_surf | (prev[k].surf_dist < cfg.radius));
            st_in[k].pp_x  = 50'(signed'({1'b0, cfg.radius})) * 50'(prev[k].nrm_x);
            st_in[k].pp_y  = 50'(signed'({1'b0, cfg.radius})) * 50'(prev[k].nrm_y);
         end
         1: begin
            st_in[k].dot = 51'(prev[k].nrm_x) * 51'(prev[k].rel_x)
                         + 51'(prev[k].nrm_y) * 51'(prev[k].rel_y);
            if (prev[k].hit) begin
               st_in[k].pos_x = sat32(66'(prev[k].near_x) + rnd(66'(prev[k].pp_x)));
               st_in[k].pos_y = sat32(66'(prev[k].near_y) + rnd(66'(prev[k].pp_y)));
            end
         end
         2: begin
            st_in[k].vn  = sat32(rnd(66'(prev[k].dot)));
            st_in[k].neg = prev[k].dot[50];
         end
         3: begin
            st_in[k].nnp_x = 50'(prev[k].vn) * 50'(prev[k].nrm_x);
            st_in[k].nnp_y = 50'(prev[k].vn) * 50'(prev[k].nrm_y);
         end
         4: begin
            st_in[k].nn_x  = sat32(rnd(66'(prev[k].nnp_x)));
            st_in[k].nn_y  = sat32(rnd(66'(prev[k].nnp_y)));
            st_in[k].tan_x = sat32(66'(prev[k].rel_x) - 66'(st_in[k].nn_x));
            st_in[k].tan_y = sat32(66'(prev[k].rel_y) - 66'(st_in[k].nn_y));
         end
         5: begin
            st_in[k].dp_x = (e_s + ONE_S) * 51'(prev[k].nn_x);
            st_in[k].dp_y = (e_s + ONE_S) * 51'(prev[k].nn_y);
            st_in[k].rp_x = (-e_s) * 51'(prev[k].nn_x);
            st_in[k].rp_y = (-e_s) * 51'(prev[k].nn_y);
            st_in[k].sq_x = 64'(prev[k].tan_x) * 64'(prev[k].tan_x);
            st_in[k].sq_y = 64'(prev[k].tan_y) * 64'(prev[k].tan_y);
         end
         6: begin
            st_in[k].d_x  = sat32(rnd(66'(prev[k].dp_x)));
            st_in[k].d_y  = sat32(rnd(66'(prev[k].dp_y)));
            st_in[k].rn_x = sat32(rnd(66'(prev[k].rp_x)));
            st_in[k].rn_y = sat32(rnd(66'(prev[k].rp_y)));
            st_in[k].lt2  = prev[k].sq_x + prev[k].sq_y;
         end
         7: begin
            st_in[k].sd_x    = 64'(prev[k].d_x) * 64'(prev[k].d_x);
            st_in[k].sd_y    = 64'(prev[k].d_y) * 64'(prev[k].d_y);
            st_in[k].lt_zero = (prev[k].lt2 == 64'd0);
         end
         8: begin
            st_in[k].ld2 = prev[k].sd_x + prev[k].sd_y;
         end
         default: begin
            st_in[k] = prev[k];
         end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (rdy[k]) st_ff[k] <= st_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_item  = st_ff[NSTG-1];

endmodule

// ===== design/pcr_sqrt.sv =====
// Two floor square roots side by side, one result bit per stage, 32 stages.
// Depends on pcr_pkg.
module pcr_sqrt import pcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int NSTG = 32;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_prev;
   logic [NSTG:0]   rdy;
   item_type        st_ff [NSTG];
   item_type        st_in [NSTG];
   item_type        prev  [NSTG];

   assign vld_prev = {vld_ff[NSTG-2:0], in_valid};

   always_comb begin
      rdy[NSTG] = out_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
      prev[0] = in_item;
      for (int k = 1; k < NSTG; k++) begin
         prev[k] = st_ff[k-1];
      end
   end

   // bring in two radicand bits, try root*4+1
   always_comb begin
      logic [35:0] rsh_t;
      logic [35:0] try_t;
      logic [35:0] rsh_d;
      logic [35:0] try_d;
      for (int k = 0; k < NSTG; k++) begin
         st_in[k] = prev[k];
         rsh_t = {prev[k].lt_rem[33:0], prev[k].lt2[63:62]};
         try_t = {2'b00, prev[k].lt_root, 2'b01};
         rsh_d = {prev[k].ld_rem[33:0], prev[k].ld2[63:62]};
         try_d = {2'b00, prev[k].ld_root, 2'b01};
         st_in[k].lt2 = {prev[k].lt2[61:0], 2'b00};
         st_in[k].ld2 = {prev[k].ld2[61:0], 2'b00};
         if (rsh_t >= try_t) begin
            st_in[k].lt_rem  = rsh_t - try_t;
            st_in[k].lt_root = {prev[k].lt_root[30:0], 1'b1};
         end else begin
            st_in[k].lt_rem  = rsh_t;
            st_in[k].lt_root = {prev[k].lt_root[30:0], 1'b0};
         end
         if (rsh_d >= try_d) begin
            st_in[k].ld_rem  = rsh_d - try_d;
            st_in[k].ld_root = {prev[k].ld_root[30:0], 1'b1};
         end else begin
            st_in[k].ld_rem  = rsh_d;
            st_in[k].ld_root = {prev[k].ld_root[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (rdy[k]) st_ff[k] <= st_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_item  = st_ff[NSTG-1];

endmodule

// ===== design/pcr_div.sv =====
// Friction ratio: one multiply stage, then a restoring quotient, one bit per stage.
// Depends on pcr_pkg.
module pcr_div import pcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int QBITS = FRAC_BITS + 1;
   localparam int NSTG  = QBITS + 1;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_prev;
   logic [NSTG:0]   rdy;
   item_type        st_ff [NSTG];
   item_type        st_in [NSTG];
   item_type        prev  [NSTG];

   assign vld_prev = {vld_ff[NSTG-2:0], in_valid};

   always_comb begin
      rdy[NSTG] = out_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
      prev[0] = in_item;
      for (int k = 1; k < NSTG; k++) begin
         prev[k] = st_ff[k-1];
      end
   end

   // the top quotient bit flags a ratio of one or more
   always_comb begin
      logic [50:0] dv;
      for (int k = 0; k < NSTG; k++) begin
         st_in[k] = prev[k];
         dv = 51'(prev[k].lt_root) << (NSTG - 1 - k);
         if (k == 0) begin
            st_in[k].div_rem = 51'(cfg.friction) * 51'(prev[k].ld_root);
            st_in[k].quot    = '0;
         end else if (prev[k].div_rem >= dv) begin
            st_in[k].div_rem = prev[k].div_rem - dv;
            st_in[k].quot    = prev[k].quot | (17'd1 << (NSTG - 1 - k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (rdy[k]) st_ff[k] <= st_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_item  = st_ff[NSTG-1];

endmodule

// ===== design/pcr_back.sv =====
// Back pipeline: tangential scaling, final velocity and output register.
// Depends on pcr_pkg.
module pcr_back import pcr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int NSTG = 2;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_prev;
   logic [NSTG:0]   rdy;
   item_type        st_ff [NSTG];
   item_type        st_in [NSTG];
   item_type        prev  [NSTG];

   assign vld_prev = {vld_ff[NSTG-2:0], in_valid};

   always_comb begin
      rdy[NSTG] = out_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
      prev[0] = in_item;
      for (int k = 1; k < NSTG; k++) begin
         prev[k] = st_ff[k-1];
      end
   end

   always_comb begin
      logic [16:0] scale;
      scale = '0;
      for (int k = 0; k < NSTG; k++) begin
         st_in[k] = prev[k];
         case (k)
         0: begin
            if (prev[k].lt_zero) begin
               scale = ONE_Q;
            end else if (prev[k].quot[16]) begin
               scale = '0;
            end else begin
               scale = ONE_Q - {1'b0, prev[k].quot[15:0]};
            end
            st_in[k].dp_x = 51'(prev[k].tan_x) * 51'(signed'({1'b0, scale}));
            st_in[k].dp_y = 51'(prev[k].tan_y) * 51'(signed'({1'b0, scale}));
         end
         1: begin
            if (prev[k].hit && prev[k].neg) begin
               st_in[k].vel_x = sat32(66'(prev[k].rn_x) + rnd(66'(prev[k].dp_x))
                                      + 66'(prev[k].wall_x));
               st_in[k].vel_y = sat32(66'(prev[k].rn_y) + rnd(66'(prev[k].dp_y))
                                      + 66'(prev[k].wall_y));
            end
         end
         default: begin
            st_in[k] = prev[k];
         end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (rdy[k]) st_ff[k] <= st_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_item  = st_ff[NSTG-1];

endmodule

// ===== design/particle_collision_response_2d.sv =====
// Particle collision response, 2D, Q16.16. Each request carries one particle and its surface
// query; penetrating particles are pushed out to the surface, their velocity relative to the
// collider is reflected with restitution and the tangential part damped by friction. The block
// takes one request per clock while the response side is ready and returns one response per
// request in order through 9 front stages, 32 square-root stages (one root bit each), 18
// friction-ratio stages (one multiply, one quotient bit each) and 2 back stages.
// Configuration is written through the csr_ port, which is always ready; write it only when no
// request is in flight. No memory, so no clearing pass after reset.
module particle_collision_response_2d import pcr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_near_x,
   input  logic signed [31:0] req_near_y,
   input  logic signed [17:0] req_normal_x,
   input  logic signed [17:0] req_normal_y,
   input  logic [30:0]        req_surface_distance,
   input  logic               req_inside_surface,
   input  logic signed [31:0] req_wall_vel_x,
   input  logic signed [31:0] req_wall_vel_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_vel_x,
   output logic signed [31:0] rsp_out_vel_y,
   output logic               rsp_collided
);

   logic [30:0] radius_ff;
   logic [16:0] restitution_ff;
   logic [18:0] friction_ff;
   logic        geo_valid_ff;
   cfg_type     cfg;
   item_type    req_item;

   item_type    front_item;
   item_type    sqrt_item;
   item_type    div_item;
   item_type    rsp_item;
   logic        front_valid, front_ready;
   logic        sqrt_valid, sqrt_ready;
   logic        div_valid, div_ready;

   // Configuration registers; clamp restitution to one and friction to four on write,
   // drop writes to unknown indexes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= '0;
         restitution_ff <= '0;
         friction_ff    <= '0;
         geo_valid_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
         CSR_RADIUS: begin
            radius_ff <= csr_wdata[30:0];
         end
         CSR_RESTITUTION: begin
            restitution_ff <= (csr_wdata[16:0] > ONE_Q) ? ONE_Q : csr_wdata[16:0];
         end
         CSR_FRICTION: begin
            friction_ff <= (csr_wdata[18:0] > FRICT_MAX) ? FRICT_MAX : csr_wdata[18:0];
         end
         CSR_GEO_VALID: begin
            geo_valid_ff <= csr_wdata[0];
         end
         default: begin
            geo_valid_ff <= geo_valid_ff;
         end
         endcase
      end
   end

   always_comb begin
      cfg.radius      = radius_ff;
      cfg.restitution = restitution_ff;
      cfg.friction    = friction_ff;
      cfg.geo_valid   = geo_valid_ff;
   end

   // Pack the request; working fields start at zero (the root stages rely on it).
   always_comb begin
      req_item           = '0;
      req_item.pos_x     = req_pos_x;
      req_item.pos_y     = req_pos_y;
      req_item.vel_x     = req_vel_x;
      req_item.vel_y     = req_vel_y;
      req_item.near_x    = req_near_x;
      req_item.near_y    = req_near_y;
      req_item.nrm_x     = req_normal_x;
      req_item.nrm_y     = req_normal_y;
      req_item.surf_dist = req_surface_distance;
      req_item.in_surf   = req_inside_surface;
      req_item.wall_x    = req_wall_vel_x;
      req_item.wall_y    = req_wall_vel_y;
   end

   // Every stage holds its own valid bit and advances when the stage after it is free or
   // moving, so bubbles are squeezed out while the response side stalls.
   pcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // |Vt| and |dVn| from the two squared lengths
   pcr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (sqrt_valid),
      .out_ready (sqrt_ready),
      .out_item  (sqrt_item)
   );

   // friction * |dVn| / |Vt|
   pcr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (sqrt_valid),
      .in_ready  (sqrt_ready),
      .in_item   (sqrt_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item)
   );

   // Last stage of the back end is the response register.
   pcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_item   (div_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_out_pos_x = rsp_item.pos_x;
   assign rsp_out_pos_y = rsp_item.pos_y;
   assign rsp_out_vel_x = rsp_item.vel_x;
   assign rsp_out_vel_y = rsp_item.vel_y;
   assign rsp_collided  = rsp_item.hit;

`ifndef SYNTHESIS
   // a ready response side must never hold off new requests
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled while response side ready");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      (restitution_ff <= ONE_Q) && (friction_ff <= FRICT_MAX))
      else $error("coefficient register beyond its clamp");
`endif

endmodule
